FILE: rtl/core/point_mass_step_quantizer_top_defines.svh
// Assertion macros for the point mass step quantizer checker.
`ifndef POINT_MASS_STEP_QUANTIZER_TOP_DEFINES_SVH
`define POINT_MASS_STEP_QUANTIZER_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PMSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PMSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/pmsq_pkg.sv
// Shared types, constants and register map of the point mass step quantizer.
package pmsq_pkg;

  localparam int NUM_POS_DEF = 16;
  localparam int NUM_VEL_DEF = 16;

  localparam int TS_W   = 17;
  localparam int STEP_W = 31;
  localparam int Q_W    = 32;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [TS_W-1:0]       TIME_STEP_RST   = 17'd655;
  localparam logic signed [Q_W-1:0] POS_LOW_RST     = -32'sd65536;
  localparam logic [STEP_W-1:0]     POS_STEP_RST    = 31'd8738;
  localparam logic signed [Q_W-1:0] VEL_LOW_RST     = -32'sd65536;
  localparam logic [STEP_W-1:0]     VEL_STEP_RST    = 31'd8738;
  localparam logic signed [Q_W-1:0] START_POS_RST   = 32'sd0;
  localparam logic                  REWARD_MODE_RST = 1'b0;

  localparam logic [2:0] REG_TIME_STEP   = 3'd0;
  localparam logic [2:0] REG_POS_LOW     = 3'd1;
  localparam logic [2:0] REG_POS_STEP    = 3'd2;
  localparam logic [2:0] REG_VEL_LOW     = 3'd3;
  localparam logic [2:0] REG_VEL_STEP    = 3'd4;
  localparam logic [2:0] REG_START_POS   = 3'd5;
  localparam logic [2:0] REG_REWARD_MODE = 3'd6;

  localparam logic REWARD_ENDS = 1'b0;
  localparam logic REWARD_DIST = 1'b1;

  typedef struct packed {
    logic load_in;
    logic restart;
    logic step;
    logic mul_en;
    logic mul_vel;
    logic upd_vel;
    logic upd_pos;
    logic walk_init;
    logic walk_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_last;
  } sts_t;

endpackage

FILE: rtl/core/pmsq_lane.sv
// Grid walk lane: nearest grid point search and range check for one axis.
module pmsq_lane #(
  parameter int COUNT = pmsq_pkg::NUM_POS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                init_i,
  input  logic                                en_i,
  input  logic signed [pmsq_pkg::Q_W-1:0]     x_i,
  input  logic signed [pmsq_pkg::Q_W-1:0]     low_i,
  input  logic        [pmsq_pkg::STEP_W-1:0]  step_i,
  output logic        [$clog2(COUNT)-1:0]     best_o,
  output logic                                last_o,
  output logic                                oor_o
);

  localparam int IW = $clog2(COUNT);
  localparam int GW = IW + 33;
  localparam int DW = GW + 1;

  logic [IW-1:0]        idx_q, best_q;
  logic signed [GW-1:0] g_q, g_d;
  logic [DW-1:0]        bestd_q, gap;
  logic signed [DW-1:0] diff;
  logic                 take;

  assign diff   = DW'(x_i) - DW'(g_q);
  assign gap    = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign g_d    = g_q + GW'(step_i);
  assign last_o = (idx_q == IW'(COUNT - 1));
  assign take   = (idx_q == '0) || (gap < bestd_q);
  assign best_o = best_q;
  assign oor_o  = (x_i < low_i) || (DW'(x_i) > DW'(g_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (init_i) begin
      idx_q <= '0;
    end else if (en_i && !last_o) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      g_q <= GW'(low_i);
    end else if (en_i) begin
      if (take) begin
        best_q  <= idx_q;
        bestd_q <= gap;
      end
      if (!last_o) begin
        g_q <= g_d;
      end
    end
  end

endmodule

FILE: rtl/core/pmsq_dp.sv
// Datapath: shared multiplier, Euler update, grid lanes and result register.
module pmsq_dp #(
  parameter int NUM_POS = pmsq_pkg::NUM_POS_DEF,
  parameter int NUM_VEL = pmsq_pkg::NUM_VEL_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pmsq_pkg::cmd_t                      cmd_i,
  output pmsq_pkg::sts_t                      sts_o,
  input  logic signed [pmsq_pkg::Q_W-1:0]     accel_i,
  input  logic        [pmsq_pkg::TS_W-1:0]    time_step_i,
  input  logic signed [pmsq_pkg::Q_W-1:0]     pos_low_i,
  input  logic        [pmsq_pkg::STEP_W-1:0]  pos_step_i,
  input  logic signed [pmsq_pkg::Q_W-1:0]     vel_low_i,
  input  logic        [pmsq_pkg::STEP_W-1:0]  vel_step_i,
  input  logic signed [pmsq_pkg::Q_W-1:0]     start_pos_i,
  input  logic                                reward_mode_i,
  output logic                                done_res_o,
  output logic        [7:0]                   state_index_o,
  output logic signed [6:0]                   reward_o
);

  localparam int PW = $clog2(NUM_POS);
  localparam int VW = $clog2(NUM_VEL);
  localparam int PRW = 50;
  localparam int SW = 35;
  localparam int QW = 2*PW + 8;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] s);
    logic signed [31:0] r;
    r = s[31:0];
    if (!s[SW-1] && (|s[SW-2:31])) begin
      r = 32'sh7FFFFFFF;
    end else if (s[SW-1] && !(&s[SW-2:31])) begin
      r = -32'sh80000000;
    end
    return r;
  endfunction

  logic signed [31:0]     accel_q, pos_q, vel_q, mul_a;
  logic signed [17:0]     ts_s;
  logic signed [PRW-1:0]  prod_q, prod_d, rnd;
  logic signed [33:0]     mr;
  logic signed [SW-1:0]   vel_sum, pos_sum;
  logic [PW-1:0]          pi;
  logic [VW-1:0]          vi;
  logic                   pos_last, vel_last, pos_oor, vel_oor;
  logic signed [PW+1:0]   dmid;
  logic [QW-1:0]          dsq;
  logic signed [6:0]      reward_d;
  logic [16:0]            index_full;

  assign ts_s    = $signed({1'b0, time_step_i});
  assign mul_a   = cmd_i.mul_vel ? vel_q : accel_q;
  assign prod_d  = PRW'(mul_a) * PRW'(ts_s);
  assign rnd     = prod_q + PRW'(32'sd32768);
  assign mr      = rnd[PRW-1:16];
  assign vel_sum = SW'(vel_q) + SW'(mr);
  assign pos_sum = SW'(pos_q) + SW'(mr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= pmsq_pkg::START_POS_RST;
      vel_q <= '0;
    end else if (cmd_i.restart) begin
      pos_q <= start_pos_i;
      vel_q <= '0;
    end else if (cmd_i.upd_vel) begin
      vel_q <= sat32(vel_sum);
    end else if (cmd_i.upd_pos) begin
      pos_q <= sat32(pos_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      accel_q <= accel_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  pmsq_lane #(.COUNT(NUM_POS)) u_pos_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_i (cmd_i.walk_init),
    .en_i   (cmd_i.walk_en),
    .x_i    (pos_q),
    .low_i  (pos_low_i),
    .step_i (pos_step_i),
    .best_o (pi),
    .last_o (pos_last),
    .oor_o  (pos_oor)
  );

  pmsq_lane #(.COUNT(NUM_VEL)) u_vel_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_i (cmd_i.walk_init),
    .en_i   (cmd_i.walk_en),
    .x_i    (vel_q),
    .low_i  (vel_low_i),
    .step_i (vel_step_i),
    .best_o (vi),
    .last_o (vel_last),
    .oor_o  (vel_oor)
  );

  assign sts_o.walk_last = pos_last && vel_last;

  assign dmid       = $signed({2'b00, pi}) - (PW+2)'(NUM_POS / 2);
  assign dsq        = QW'(dmid) * QW'(dmid);
  assign index_full = 17'(pi) * 17'(NUM_VEL) + 17'(vi);

  always_comb begin
    unique case (reward_mode_i)
      pmsq_pkg::REWARD_ENDS: begin
        reward_d = ((pi == '0) || (pi == PW'(NUM_POS - 1))) ? -7'sd1 : 7'sd0;
      end
      pmsq_pkg::REWARD_DIST: begin
        reward_d = (dsq > QW'(64)) ? -7'sd64 : -$signed(7'(dsq));
      end
      default: begin
        reward_d = 7'sd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      done_res_o    <= cmd_i.step && (pos_oor || vel_oor);
      state_index_o <= index_full[7:0];
      reward_o      <= reward_d;
    end
  end

endmodule

FILE: rtl/core/pmsq_ctrl.sv
// Controller: per request, multiply and update (not on reset), walk, output.
module pmsq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           action_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pmsq_pkg::cmd_t cmd_o,
  input  pmsq_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_V,
    ST_ADD_V,
    ST_MUL_P,
    ST_ADD_P,
    ST_WALK_INIT,
    ST_WALK,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   in_stall_q, out_valid_q, step_q;
  logic   accept, out_free;

  assign accept      = (state_q == ST_IDLE) && in_valid_i && !in_stall_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = accept;
    cmd_o.restart   = accept && action_i;
    cmd_o.step      = step_q;
    cmd_o.mul_en    = (state_q == ST_MUL_V) || (state_q == ST_MUL_P);
    cmd_o.mul_vel   = (state_q == ST_MUL_P);
    cmd_o.upd_vel   = (state_q == ST_ADD_V);
    cmd_o.upd_pos   = (state_q == ST_ADD_P);
    cmd_o.walk_init = (state_q == ST_WALK_INIT);
    cmd_o.walk_en   = (state_q == ST_WALK);
    cmd_o.out_load  = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= 1'b0;
    end else begin
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            in_stall_q <= 1'b1;
            step_q     <= !action_i;
            state_q    <= action_i ? ST_WALK_INIT : ST_MUL_V;
          end
        end
        ST_MUL_V:     state_q <= ST_ADD_V;
        ST_ADD_V:     state_q <= ST_MUL_P;
        ST_MUL_P:     state_q <= ST_ADD_P;
        ST_ADD_P:     state_q <= ST_WALK_INIT;
        ST_WALK_INIT: state_q <= ST_WALK;
        ST_WALK: begin
          if (sts_i.walk_last) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            in_stall_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/point_mass_step_quantizer_top.sv
// Top level of the point mass step quantizer: register port, controller and datapath.
// An accepted step request makes two passes through one shared 32x18 multiplier with a
// saturating add after each, then a walk set-up state, a walk that checks one position
// and one velocity grid point per cycle, and a final state that loads the done flag, state
// index and reward; a reset action skips the two passes. One request is in flight at a
// time; the next one is taken in the cycle after the result is loaded, while that result
// may still wait in the output register. A stall on the result holds the final state
// until the output register is free. Write the registers at byte address 4*i only while
// no request is in flight.
module point_mass_step_quantizer_top #(
  parameter int NUM_POS = pmsq_pkg::NUM_POS_DEF,
  parameter int NUM_VEL = pmsq_pkg::NUM_VEL_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic signed [pmsq_pkg::Q_W-1:0]   accel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              done_res_o,
  output logic        [7:0]                 state_index_o,
  output logic signed [6:0]                 reward_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic        [pmsq_pkg::ADDR_W-1:0] paddr,
  input  logic        [pmsq_pkg::DATA_W-1:0] pwdata,
  output logic        [pmsq_pkg::DATA_W-1:0] prdata,
  output logic                              pready
);

  logic        [pmsq_pkg::TS_W-1:0]   time_step_q;
  logic signed [pmsq_pkg::Q_W-1:0]    pos_low_q, vel_low_q, start_pos_q;
  logic        [pmsq_pkg::STEP_W-1:0] pos_step_q, vel_step_q;
  logic                               reward_mode_q;
  logic                               wr_en;
  logic        [2:0]                  reg_idx;
  pmsq_pkg::cmd_t                     cmd;
  pmsq_pkg::sts_t                     sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q   <= pmsq_pkg::TIME_STEP_RST;
      pos_low_q     <= pmsq_pkg::POS_LOW_RST;
      pos_step_q    <= pmsq_pkg::POS_STEP_RST;
      vel_low_q     <= pmsq_pkg::VEL_LOW_RST;
      vel_step_q    <= pmsq_pkg::VEL_STEP_RST;
      start_pos_q   <= pmsq_pkg::START_POS_RST;
      reward_mode_q <= pmsq_pkg::REWARD_MODE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        pmsq_pkg::REG_TIME_STEP:   time_step_q   <= pwdata[pmsq_pkg::TS_W-1:0];
        pmsq_pkg::REG_POS_LOW:     pos_low_q     <= $signed(pwdata);
        pmsq_pkg::REG_POS_STEP:    pos_step_q    <= pwdata[pmsq_pkg::STEP_W-1:0];
        pmsq_pkg::REG_VEL_LOW:     vel_low_q     <= $signed(pwdata);
        pmsq_pkg::REG_VEL_STEP:    vel_step_q    <= pwdata[pmsq_pkg::STEP_W-1:0];
        pmsq_pkg::REG_START_POS:   start_pos_q   <= $signed(pwdata);
        pmsq_pkg::REG_REWARD_MODE: reward_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pmsq_pkg::REG_TIME_STEP:   prdata = pmsq_pkg::DATA_W'(time_step_q);
      pmsq_pkg::REG_POS_LOW:     prdata = pos_low_q;
      pmsq_pkg::REG_POS_STEP:    prdata = pmsq_pkg::DATA_W'(pos_step_q);
      pmsq_pkg::REG_VEL_LOW:     prdata = vel_low_q;
      pmsq_pkg::REG_VEL_STEP:    prdata = pmsq_pkg::DATA_W'(vel_step_q);
      pmsq_pkg::REG_START_POS:   prdata = start_pos_q;
      pmsq_pkg::REG_REWARD_MODE: prdata = pmsq_pkg::DATA_W'(reward_mode_q);
      default:                   prdata = '0;
    endcase
  end

  pmsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pmsq_dp #(
    .NUM_POS (NUM_POS),
    .NUM_VEL (NUM_VEL)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .accel_i       (accel_i),
    .time_step_i   (time_step_q),
    .pos_low_i     (pos_low_q),
    .pos_step_i    (pos_step_q),
    .vel_low_i     (vel_low_q),
    .vel_step_i    (vel_step_q),
    .start_pos_i   (start_pos_q),
    .reward_mode_i (reward_mode_q),
    .done_res_o    (done_res_o),
    .state_index_o (state_index_o),
    .reward_o      (reward_o)
  );

endmodule

FILE: rtl/core/pmsq_checker.sv
// Port-level checker for the point mass step quantizer and its bind.
`include "point_mass_step_quantizer_top_defines.svh"

module pmsq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] reward_o
);

  `PMSQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")
  `PMSQ_ASSERT(a_busy_after_req, in_valid_i && !in_stall_o |=> in_stall_o, "request not held off")
  `PMSQ_ASSERT(a_result_on_release, $fell(in_stall_o) |-> out_valid_o, "release without result")
  `PMSQ_ASSERT(a_reward_sign, !out_valid_o || reward_o[6] || (reward_o == 7'd0), "reward positive")

endmodule

bind point_mass_step_quantizer_top pmsq_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .reward_o    (reward_o)
);
